// ----- src/kqt_pkg.sv -----
package kqt_pkg;

   localparam int MAX_PARTS = 64;
   localparam int ADDR_W    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int COUNT_W   = $clog2(MAX_PARTS + 1);
   localparam int POS_W     = 6;
   localparam int USED_W    = 7;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_SEARCH = 2'd1;
   localparam logic [1:0] FUNC_UPDATE = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STATUS_EXISTS    = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_BEYOND    = 3'd4;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] part_key;
      logic signed [31:0] quantity_value;
      logic [5:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [POS_W-1:0]   entry_position;
      logic signed [31:0] key_out;
      logic signed [31:0] quantity_out;
      logic [USED_W-1:0]  entries_used;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] quantity;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } ram_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_UPDATE
   } fsm_state_type;

endpackage

// ----- src/keyed_quantity_table.sv -----
// Reads by index fetch the entry from the RAM; any op on an empty table and a read beyond
// the count are answered straight from idle; insert/search/update scan one entry per cycle,
// and an update that hits writes the saturated sum back in a further state.
// Throughput: one item at a time; busy drops as the strobe rises, next item accepted then.
// Reset clears the state, the entry count and the result strobe; the entry RAM keeps its contents.
// Results are a one-cycle strobe; the receiver cannot stall.
module keyed_quantity_table
   import kqt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   fsm_state_type state_ff, state_in;
   req_type       req_ff, req_in;
   logic [ADDR_W-1:0]  scan_ff, scan_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   entry_type     hit_ff, hit_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;
   ram_wr_type        wr;

   logic        accept;
   logic        key_match;
   logic        scan_last;
   logic        table_full;
   logic        idx_in_range;
   logic [32:0] upd_sum;
   logic signed [31:0] upd_quantity;

   kqt_entry_ram u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   function automatic rsp_type make_rsp(input logic [2:0] st, input logic [ADDR_W-1:0] pos,
                                        input entry_type ent, input logic [COUNT_W-1:0] cnt);
      rsp_type r;
      r.status         = st;
      r.entry_position = POS_W'(pos);
      r.key_out        = ent.key;
      r.quantity_out   = ent.quantity;
      r.entries_used   = USED_W'(cnt);
      return r;
   endfunction

   function automatic rsp_type empty_rsp(input logic [2:0] st, input logic [COUNT_W-1:0] cnt);
      rsp_type r;
      r.status         = st;
      r.entry_position = '0;
      r.key_out        = '0;
      r.quantity_out   = '0;
      r.entries_used   = USED_W'(cnt);
      return r;
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign key_match    = (rd_data.key == req_ff.part_key);
   assign scan_last    = ((COUNT_W'(scan_ff) + COUNT_W'(1)) == count_ff);
   assign table_full   = (32'(count_ff) >= 32'(MAX_PARTS));
   assign idx_in_range = (32'(req_item.read_index) < 32'(count_ff));

   // saturating add on a 33-bit sum: top two bits differ on overflow
   assign upd_sum = {hit_ff.quantity[31], hit_ff.quantity}
                  + {req_ff.quantity_value[31], req_ff.quantity_value};
   always_comb begin
      if (upd_sum[32] != upd_sum[31]) begin
         upd_quantity = upd_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         upd_quantity = $signed(upd_sum[31:0]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.func == FUNC_READ) begin
                  if (idx_in_range) state_in = ST_FETCH;
               end else if (count_ff != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               state_in = (req_ff.func == FUNC_UPDATE) ? ST_UPDATE : ST_IDLE;
            end else if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH:  state_in = ST_IDLE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath control and result
   always_comb begin
      req_in       = req_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      rd_addr      = ADDR_W'(scan_ff + ADDR_W'(1));
      wr.en        = 1'b0;
      wr.addr      = ADDR_W'(count_ff);
      wr.data.key      = req_ff.part_key;
      wr.data.quantity = req_ff.quantity_value;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_item.func == FUNC_READ) ? ADDR_W'(req_item.read_index) : '0;
            if (accept) begin
               req_in  = req_item;
               scan_in = '0;
               if (req_item.func == FUNC_READ) begin
                  if (!idx_in_range) begin
                     rsp_in       = empty_rsp(STATUS_BEYOND, count_ff);
                     rsp_valid_in = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  if (req_item.func == FUNC_INSERT) begin
                     wr.en            = 1'b1;
                     wr.addr          = '0;
                     wr.data.key      = req_item.part_key;
                     wr.data.quantity = req_item.quantity_value;
                     count_in         = COUNT_W'(1);
                     rsp_in           = make_rsp(STATUS_OK, '0, wr.data, COUNT_W'(1));
                  end else begin
                     rsp_in = empty_rsp(STATUS_NOT_FOUND, count_ff);
                  end
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               hit_in = rd_data;
               unique case (req_ff.func)
                  FUNC_INSERT: begin
                     rsp_in       = make_rsp(STATUS_EXISTS, scan_ff, rd_data, count_ff);
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_SEARCH: begin
                     rsp_in       = make_rsp(STATUS_OK, scan_ff, rd_data, count_ff);
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end else if (scan_last) begin
               rsp_valid_in = 1'b1;
               if (req_ff.func == FUNC_INSERT) begin
                  if (table_full) begin
                     rsp_in = empty_rsp(STATUS_FULL, count_ff);
                  end else begin
                     wr.en    = 1'b1;
                     count_in = count_ff + COUNT_W'(1);
                     rsp_in   = make_rsp(STATUS_OK, ADDR_W'(count_ff), wr.data,
                                         count_ff + COUNT_W'(1));
                  end
               end else begin
                  rsp_in = empty_rsp(STATUS_NOT_FOUND, count_ff);
               end
            end else begin
               scan_in = ADDR_W'(scan_ff + ADDR_W'(1));
            end
         end
         ST_FETCH: begin
            rsp_in       = make_rsp(STATUS_OK, ADDR_W'(req_ff.read_index), rd_data, count_ff);
            rsp_valid_in = 1'b1;
         end
         ST_UPDATE: begin
            wr.en            = 1'b1;
            wr.addr          = scan_ff;
            wr.data.key      = hit_ff.key;
            wr.data.quantity = upd_quantity;
            rsp_in           = make_rsp(STATUS_OK, scan_ff, wr.data, count_ff);
            rsp_valid_in     = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      scan_ff <= scan_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ----- src/kqt_entry_ram.sv -----
module kqt_entry_ram
   import kqt_pkg::*;
(
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data,
   input  ram_wr_type        wr
);

   entry_type mem [MAX_PARTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import kqt_pkg::*;

   typedef struct {
      req_type req;
      bit      drain;   // hold off until every result is back
   } queued_op_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   keyed_quantity_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // Shadow copy of the table
   logic signed [31:0] shadow_key [MAX_PARTS];
   logic signed [31:0] shadow_qty [MAX_PARTS];
   int                 shadow_count = 0;

   queued_op_type      pending_ops[$];
   rsp_type            due_results[$];
   logic signed [31:0] used_keys[$];
   int                 fail_count = 0;
   bit                 taken = 1'b0;
   int                 burst_left = 1;
   int                 gap_left = 0;

   function automatic rsp_type apply_table_op(req_type op);
      rsp_type res;
      int      hit;
      int      pos;
      bit      has_entry;
      longint  sum;
      res       = '0;
      hit       = -1;
      pos       = 0;
      has_entry = 1'b0;
      if (op.func != FUNC_READ) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_key[i] == op.part_key) hit = i;
         end
      end
      case (op.func)
         FUNC_INSERT: begin
            if (hit >= 0) begin
               res.status = STATUS_EXISTS;
               pos        = hit;
               has_entry  = 1'b1;
            end else if (shadow_count >= MAX_PARTS) begin
               res.status = STATUS_FULL;
            end else begin
               pos             = shadow_count;
               shadow_key[pos] = op.part_key;
               shadow_qty[pos] = op.quantity_value;
               shadow_count++;
               res.status = STATUS_OK;
               has_entry  = 1'b1;
            end
         end
         FUNC_SEARCH: begin
            if (hit >= 0) begin
               res.status = STATUS_OK;
               pos        = hit;
               has_entry  = 1'b1;
            end else begin
               res.status = STATUS_NOT_FOUND;
            end
         end
         FUNC_UPDATE: begin
            if (hit >= 0) begin
               sum = longint'(shadow_qty[hit]) + longint'(op.quantity_value);
               if (sum > 64'sd2147483647) sum = 64'sd2147483647;
               if (sum < -64'sd2147483648) sum = -64'sd2147483648;
               shadow_qty[hit] = sum[31:0];
               res.status = STATUS_OK;
               pos        = hit;
               has_entry  = 1'b1;
            end else begin
               res.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            if (int'(op.read_index) < shadow_count) begin
               res.status = STATUS_OK;
               pos        = op.read_index;
               has_entry  = 1'b1;
            end else begin
               res.status = STATUS_BEYOND;
            end
         end
      endcase
      if (has_entry) begin
         res.entry_position = POS_W'(pos);
         res.key_out        = shadow_key[pos];
         res.quantity_out   = shadow_qty[pos];
      end
      res.entries_used = USED_W'(shadow_count);
      return res;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic push_op(logic [1:0] func, logic signed [31:0] key,
                          logic signed [31:0] value, logic [5:0] index, bit drain);
      queued_op_type op;
      op.req.func           = func;
      op.req.part_key       = key;
      op.req.quantity_value = value;
      op.req.read_index     = index;
      op.drain              = drain;
      pending_ops.push_back(op);
      if (func == FUNC_INSERT) used_keys.push_back(key);
   endtask

   function automatic logic signed [31:0] fresh_key();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_key();
      if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      return fresh_key();
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3: return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   // Driver: presents the head of the pending queue, bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               case ($urandom_range(0, 3))
                  1: gap_left = $urandom_range(1, 5);
                  2: gap_left = $urandom_range(6, 80);
                  default: gap_left = 0;
               endcase
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_ops.size() == 0 ||
                      (pending_ops[0].drain && due_results.size() != 0)) begin
            start <= 1'b0;
         end else begin
            start    <= 1'b1;
            req_item <= pending_ops[0].req;
         end
      end
   end

   // Monitor: records accepted items and checks each result strobe
   always @(posedge clock) begin
      rsp_type want;
      taken = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               $error("result with no item outstanding");
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("status", want.status, rsp_item.status);
               check_field("entry_position", want.entry_position,
                           rsp_item.entry_position);
               check_field("key_out", want.key_out, rsp_item.key_out);
               check_field("quantity_out", want.quantity_out, rsp_item.quantity_out);
               check_field("entries_used", want.entries_used, rsp_item.entries_used);
            end
         end
         if (start && !busy) begin
            due_results.push_back(apply_table_op(req_item));
            void'(pending_ops.pop_front());
            taken = 1'b1;
         end
      end
   end

   initial begin
      int ins_pct;
      int sel;
      int waited;
      logic [1:0] func;

      // empty table: every operation misses
      push_op(FUNC_READ,   0, 0, 6'd0, 1'b0);
      push_op(FUNC_SEARCH, 32'sh7FFF_FFFF, 0, 6'd0, 1'b0);
      push_op(FUNC_UPDATE, 32'sh8000_0000, 5, 6'd0, 1'b0);
      push_op(FUNC_READ,   0, 0, 6'd63, 1'b0);
      // key and quantity extremes
      push_op(FUNC_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 6'd0, 1'b0);
      push_op(FUNC_INSERT, 32'sh8000_0000, 32'sh8000_0000, 6'd0, 1'b0);
      push_op(FUNC_INSERT, 0, 0, 6'd0, 1'b0);
      push_op(FUNC_INSERT, -1, -1, 6'h3F, 1'b0);
      // duplicate insert
      push_op(FUNC_INSERT, 32'sh7FFF_FFFF, 123, 6'd0, 1'b0);
      push_op(FUNC_SEARCH, 32'sh8000_0000, 0, 6'd0, 1'b0);
      push_op(FUNC_SEARCH, -1, 0, 6'd0, 1'b0);
      push_op(FUNC_SEARCH, 77, 0, 6'd0, 1'b0);
      // saturation both ways, then back off the limit
      push_op(FUNC_UPDATE, 32'sh7FFF_FFFF, 1, 6'd0, 1'b0);
      push_op(FUNC_UPDATE, 32'sh8000_0000, -1, 6'd0, 1'b0);
      push_op(FUNC_UPDATE, 0, 32'sh8000_0000, 6'd0, 1'b0);
      push_op(FUNC_UPDATE, 0, 32'sh8000_0000, 6'd0, 1'b0);
      push_op(FUNC_UPDATE, -1, 32'sh7FFF_FFFF, 6'd0, 1'b0);
      push_op(FUNC_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF, 6'd0, 1'b0);
      push_op(FUNC_UPDATE, 55, 1, 6'd0, 1'b0);
      push_op(FUNC_READ,   0, 0, 6'd0, 1'b0);
      push_op(FUNC_READ,   0, 0, 6'd3, 1'b0);
      push_op(FUNC_READ,   0, 0, 6'd4, 1'b0);
      push_op(FUNC_READ,   0, 0, 6'd63, 1'b0);

      // random mix; inserts grow later so the table fills and stays full
      for (int i = 0; i < 700; i++) begin
         ins_pct = (i < 300) ? 15 : 35;
         sel = $urandom_range(0, 99);
         if (sel < ins_pct) func = FUNC_INSERT;
         else func = 2'($urandom_range(FUNC_SEARCH, FUNC_READ));
         case (func)
            FUNC_INSERT:
               push_op(func, ($urandom_range(0, 4) == 0) ? pick_key() : fresh_key(),
                       pick_value(), 6'($urandom), i % 150 == 0);
            FUNC_READ:
               push_op(func, $urandom, $urandom,
                       ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 63)) :
                       6'($urandom_range(0, (used_keys.size() > 63) ? 63 :
                                            used_keys.size())),
                       i % 150 == 0);
            default:
               push_op(func, pick_key(), pick_value(), 6'($urandom), i % 150 == 0);
         endcase
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0) @(posedge clock);
      waited = 0;
      while (due_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (80) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("%0d results never arrived", due_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
